// ----- hdl/fpsc_pkg.sv -----
// Shared types and constants for the fixed-point sine/cosine pipeline.
`timescale 1ns / 1ps

package fpsc_pkg;

  localparam int PHASE_W = 20;
  localparam int ANG_W   = 18;
  localparam int PROD_W  = 2 * ANG_W;
  localparam int OUT_W   = 18;
  localparam int TERM_W  = 19;
  localparam int SUM_W   = 22;

  // stages inside the power unit, and stages in the whole pipeline
  localparam int POW_STAGES = 5;
  localparam int NUM_STAGES = 8;

  typedef enum logic {
    OP_SIN = 1'b0,
    OP_COS = 1'b1
  } op_t;

  typedef struct packed {
    op_t  op;
    logic quarter;
    logic neg;
  } ctl_t;

  // sine: a=x1 b=x3 c=x5 d=x7; cosine: a=x2 b=x4 c=x6 d=x8
  typedef struct packed {
    logic [ANG_W-1:0] a;
    logic [ANG_W-1:0] b;
    logic [ANG_W-1:0] c;
    logic [ANG_W-1:0] d;
  } terms_t;

  localparam logic [ANG_W-1:0] SIN_K1 = 18'd205887;
  localparam logic [ANG_W-1:0] SIN_K3 = 18'd169336;
  localparam logic [ANG_W-1:0] SIN_K5 = 18'd167014;
  localparam logic [ANG_W-1:0] SIN_K7 = 18'd150000;
  localparam logic [ANG_W-1:0] COS_K2 = 18'd161704;
  localparam logic [ANG_W-1:0] COS_K4 = 18'd132996;
  localparam logic [ANG_W-1:0] COS_K6 = 18'd175016;
  localparam logic [ANG_W-1:0] COS_K8 = 18'd241700;

  localparam int SIN_SH1 = 17;
  localparam int SIN_SH3 = 18;
  localparam int SIN_SH5 = 21;
  localparam int SIN_SH7 = 25;
  localparam int COS_SH2 = 17;
  localparam int COS_SH4 = 19;
  localparam int COS_SH6 = 23;
  localparam int COS_SH8 = 28;

  localparam logic signed [SUM_W-1:0] COS_ONE  = 22'sd262144;
  localparam logic signed [SUM_W-1:0] UNIT_OUT = 22'sd131072;
  localparam logic [OUT_W-1:0]        SAT_POS  = 18'h1ffff;
  localparam logic [OUT_W-1:0]        SAT_NEG  = 18'h20000;

endpackage

// ----- hdl/fpsc_powers.sv -----
// Phase fold and power-series pipeline (five stages) for the sine/cosine unit.
`timescale 1ns / 1ps

module fpsc_powers (
  input  logic                                  clk,
  input  logic [fpsc_pkg::POW_STAGES-1:0]       en,
  input  logic [fpsc_pkg::PHASE_W-1:0]          phase,
  input  logic                                  opcode,
  output fpsc_pkg::terms_t                      terms,
  output fpsc_pkg::ctl_t                        ctl
);

  localparam int AW = fpsc_pkg::ANG_W;
  localparam int PW = fpsc_pkg::PROD_W;

  logic [AW-1:0] low_nxt;
  logic [AW-1:0] x1_nxt;
  fpsc_pkg::ctl_t ctl_nxt;

  logic [AW-1:0] x1_0_r;
  fpsc_pkg::ctl_t ctl_0_r;
  logic [AW-1:0] x1_1_r, x2_1_r;
  fpsc_pkg::ctl_t ctl_1_r;
  logic [AW-1:0] x1_2_r, x2_2_r, b_2_r;
  fpsc_pkg::ctl_t ctl_2_r;
  logic [AW-1:0] x1_3_r, x2_3_r, b_3_r, c_3_r, e_3_r;
  fpsc_pkg::ctl_t ctl_3_r;
  fpsc_pkg::terms_t terms_r;
  fpsc_pkg::ctl_t ctl_4_r;

  logic [AW-1:0] mop_nxt;
  logic [PW-1:0] sq_p, b_p, c_p, e_p, d_p;
  fpsc_pkg::terms_t terms_nxt;

  // fold into the first quadrant; bit 18 mirrors the argument
  always_comb begin
    low_nxt = phase[AW-1:0];
    x1_nxt  = phase[AW] ? AW'({1'b1, {AW{1'b0}}} - {1'b0, low_nxt}) : low_nxt;
    ctl_nxt.op      = fpsc_pkg::op_t'(opcode);
    ctl_nxt.quarter = phase[AW] && (low_nxt == '0);
    ctl_nxt.neg     = (fpsc_pkg::op_t'(opcode) == fpsc_pkg::OP_COS) ?
                      (phase[AW+1] ^ phase[AW]) : phase[AW+1];
  end

  assign sq_p    = PW'(x1_0_r) * PW'(x1_0_r);
  assign mop_nxt = (ctl_1_r.op == fpsc_pkg::OP_COS) ? x2_1_r : x1_1_r;
  assign b_p     = PW'(x2_1_r) * PW'(mop_nxt);
  assign c_p     = PW'(x2_2_r) * PW'(b_2_r);
  assign e_p     = PW'(b_2_r) * PW'(b_2_r);
  assign d_p     = PW'(x2_3_r) * PW'(c_3_r);

  always_comb begin
    terms_nxt.a = (ctl_3_r.op == fpsc_pkg::OP_COS) ? x2_3_r : x1_3_r;
    terms_nxt.b = b_3_r;
    terms_nxt.c = c_3_r;
    terms_nxt.d = (ctl_3_r.op == fpsc_pkg::OP_COS) ? e_3_r : d_p[PW-1:AW];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1_0_r  <= x1_nxt;
      ctl_0_r <= ctl_nxt;
    end
    if (en[1]) begin
      x1_1_r  <= x1_0_r;
      x2_1_r  <= sq_p[PW-1:AW];
      ctl_1_r <= ctl_0_r;
    end
    if (en[2]) begin
      x1_2_r  <= x1_1_r;
      x2_2_r  <= x2_1_r;
      b_2_r   <= b_p[PW-1:AW];
      ctl_2_r <= ctl_1_r;
    end
    if (en[3]) begin
      x1_3_r  <= x1_2_r;
      x2_3_r  <= x2_2_r;
      b_3_r   <= b_2_r;
      c_3_r   <= c_p[PW-1:AW];
      e_3_r   <= e_p[PW-1:AW];
      ctl_3_r <= ctl_2_r;
    end
    if (en[4]) begin
      terms_r <= terms_nxt;
      ctl_4_r <= ctl_3_r;
    end
  end

  assign terms = terms_r;
  assign ctl   = ctl_4_r;

endmodule

// ----- hdl/fixed_point_sine_cosine_unit.sv -----
// Top level of the pipelined fixed-point sine/cosine unit.
//
// Input beat: in_phase (20 bits, 2^20 per turn) and in_opcode (0 sine,
// 1 cosine), taken when in_valid is high and in_stall is low. Result beat:
// out_result, 18-bit two's complement scaled by 2^17 and saturated, so +1
// reads as 131071. A beat is delivered when out_valid is high and out_stall
// is low.
// The pipeline has eight register stages: fold, four power-series multiply
// stages, coefficient products, sum, and sign/saturate into the output
// register. out_valid rises once the beat reaches the output register;
// throughput is one beat per cycle while out_stall is low, set by one
// 18x18 multiplier depth per stage.
// Each stage carries a valid bit. When the receiver stalls, the output
// register holds and earlier stages keep advancing into empty slots, so
// in_stall rises only once every stage is full. Nothing is dropped or
// repeated. Synchronous reset clears all valid bits; the data registers
// are not reset.
`timescale 1ns / 1ps

module fixed_point_sine_cosine_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fpsc_pkg::PHASE_W-1:0]     in_phase,
  input  logic                             in_opcode,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [fpsc_pkg::OUT_W-1:0] out_result
);

  localparam int NS  = fpsc_pkg::NUM_STAGES;
  localparam int PS  = fpsc_pkg::POW_STAGES;
  localparam int PW  = fpsc_pkg::PROD_W;
  localparam int TW  = fpsc_pkg::TERM_W;
  localparam int SW  = fpsc_pkg::SUM_W;
  localparam int OW  = fpsc_pkg::OUT_W;

  logic [NS-1:0] v_r, v_nxt, en;

  fpsc_pkg::terms_t terms;
  fpsc_pkg::ctl_t   ctl_p;

  logic          cos_sel;
  logic [PW-1:0] prod1, prod2, prod3, prod4;
  logic [TW-1:0] p1_nxt, p2_nxt, p3_nxt, p4_nxt;
  logic [TW-1:0] p1_r, p2_r, p3_r, p4_r;
  fpsc_pkg::ctl_t ctl_5_r, ctl_6_r;
  logic signed [SW-1:0] sum_nxt, sum_r;
  logic signed [SW-1:0] half_nxt, sgn_nxt;
  logic [OW-1:0]        res_nxt;
  logic [OW-1:0]        res_r;

  // a stage advances when it is empty or the next one advances
  always_comb begin
    en[NS-1] = !v_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NS; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall = !en[0];

  fpsc_powers u_powers (
    .clk    (clk),
    .en     (en[PS-1:0]),
    .phase  (in_phase),
    .opcode (in_opcode),
    .terms  (terms),
    .ctl    (ctl_p)
  );

  // weight each power by its coefficient
  always_comb begin
    cos_sel = (ctl_p.op == fpsc_pkg::OP_COS);
    prod1 = PW'(terms.a) * PW'(cos_sel ? fpsc_pkg::COS_K2 : fpsc_pkg::SIN_K1);
    prod2 = PW'(terms.b) * PW'(cos_sel ? fpsc_pkg::COS_K4 : fpsc_pkg::SIN_K3);
    prod3 = PW'(terms.c) * PW'(cos_sel ? fpsc_pkg::COS_K6 : fpsc_pkg::SIN_K5);
    prod4 = PW'(terms.d) * PW'(cos_sel ? fpsc_pkg::COS_K8 : fpsc_pkg::SIN_K7);
    p1_nxt = TW'(cos_sel ? (prod1 >> fpsc_pkg::COS_SH2) : (prod1 >> fpsc_pkg::SIN_SH1));
    p2_nxt = TW'(cos_sel ? (prod2 >> fpsc_pkg::COS_SH4) : (prod2 >> fpsc_pkg::SIN_SH3));
    p3_nxt = TW'(cos_sel ? (prod3 >> fpsc_pkg::COS_SH6) : (prod3 >> fpsc_pkg::SIN_SH5));
    p4_nxt = TW'(cos_sel ? (prod4 >> fpsc_pkg::COS_SH8) : (prod4 >> fpsc_pkg::SIN_SH7));
  end

  // alternate-sign sum; cosine starts from one at scale 2^18
  always_comb begin
    if (ctl_5_r.op == fpsc_pkg::OP_COS) begin
      sum_nxt = fpsc_pkg::COS_ONE
              - $signed({{(SW-TW){1'b0}}, p1_r}) + $signed({{(SW-TW){1'b0}}, p2_r})
              - $signed({{(SW-TW){1'b0}}, p3_r}) + $signed({{(SW-TW){1'b0}}, p4_r});
    end else begin
      sum_nxt = $signed({{(SW-TW){1'b0}}, p1_r}) - $signed({{(SW-TW){1'b0}}, p2_r})
              + $signed({{(SW-TW){1'b0}}, p3_r}) - $signed({{(SW-TW){1'b0}}, p4_r});
    end
  end

  // halve, force quarter points, apply sign, saturate
  always_comb begin
    half_nxt = sum_r >>> 1;
    if (ctl_6_r.quarter) begin
      half_nxt = (ctl_6_r.op == fpsc_pkg::OP_COS) ? '0 : fpsc_pkg::UNIT_OUT;
    end
    sgn_nxt = ctl_6_r.neg ? -half_nxt : half_nxt;
    if (sgn_nxt[OW] != sgn_nxt[OW-1]) begin
      res_nxt = sgn_nxt[OW] ? fpsc_pkg::SAT_NEG : fpsc_pkg::SAT_POS;
    end else begin
      res_nxt = sgn_nxt[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[PS]) begin
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      p3_r    <= p3_nxt;
      p4_r    <= p4_nxt;
      ctl_5_r <= ctl_p;
    end
    if (en[PS+1]) begin
      sum_r   <= sum_nxt;
      ctl_6_r <= ctl_5_r;
    end
    if (en[PS+2]) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid  = v_r[NS-1];
  assign out_result = $signed(res_r);

  // a free slot anywhere, or a draining output, must let a beat in
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!(&v_r) || !out_stall) |-> !in_stall)
    else $error("input stalled while pipeline has room");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted beat missing from first stage");

  a_cos_quarter_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-2] && en[NS-1] && ctl_6_r.quarter && (ctl_6_r.op == fpsc_pkg::OP_COS))
    |=> (out_valid && (res_r == '0)))
    else $error("cosine quarter point not zero");

  a_sin_quarter_one: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-2] && en[NS-1] && ctl_6_r.quarter && (ctl_6_r.op == fpsc_pkg::OP_SIN))
    |=> (out_valid && ((res_r == fpsc_pkg::SAT_POS) || (res_r == fpsc_pkg::SAT_NEG))))
    else $error("sine quarter point not full scale");

endmodule
